[rtl/core/rpa_pkg.sv]
// rpa_pkg: shared widths, codes and controller/datapath interface types
// for the refcounted page allocator; no dependencies
`timescale 1ns / 1ps

package rpa_pkg;

   localparam int PAGE_BITS  = 15;
   localparam int NUM_PAGES  = 2 ** PAGE_BITS;
   localparam int DEPTH_BITS = PAGE_BITS + 1;
   localparam int COUNT_BITS = 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_ADDREF = 2'd2;
   localparam logic [1:0] MODE_COW    = 2'd3;

   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_OOM  = 3'd1;
   localparam logic [2:0] ST_BAD  = 3'd2;
   localparam logic [2:0] ST_KEPT = 3'd3;
   localparam logic [2:0] ST_SAT  = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_EXEC   = 4'b0100,
      S_WRITE2 = 4'b1000
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic exec;
      logic write2;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic slot_free;
      logic need_write2;
   } dp_status_type;

endpackage

[rtl/core/rpa_ctrl.sv]
// rpa_ctrl: sequencer for the page allocator (clear sweep, accept, execute,
// second count write); depends on rpa_pkg
`timescale 1ns / 1ps

module rpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rpa_pkg::dp_status_type status,
   output rpa_pkg::ctrl_cmd_type  cmd
);

   rpa_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         rpa_pkg::S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = rpa_pkg::S_IDLE;
         end
         rpa_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = rpa_pkg::S_EXEC;
         end
         rpa_pkg::S_EXEC: begin
            // hold here until the response register can take the result
            if (status.slot_free) begin
               cmd.exec = 1'b1;
               state_in = status.need_write2 ? rpa_pkg::S_WRITE2 : rpa_pkg::S_IDLE;
            end
         end
         rpa_pkg::S_WRITE2: begin
            cmd.write2 = 1'b1;
            state_in   = rpa_pkg::S_IDLE;
         end
         default: begin
            state_in = rpa_pkg::S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/rpa_dpath.sv]
// rpa_dpath: count memory, free stack memory, stack depth, config register
// and response register; depends on rpa_pkg
`timescale 1ns / 1ps

module rpa_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  rpa_pkg::ctrl_cmd_type               cmd,
   output rpa_pkg::dp_status_type              status,
   input  logic [1:0]                          req_mode,
   input  logic [rpa_pkg::PAGE_BITS-1:0]       req_page_number,
   input  logic                                csr_valid,
   input  logic [rpa_pkg::PAGE_BITS-1:0]       csr_first_usable_page,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rpa_pkg::PAGE_BITS-1:0]       rsp_result_page,
   output logic [2:0]                          rsp_status,
   output logic [rpa_pkg::COUNT_BITS-1:0]      rsp_ref_count,
   output logic [rpa_pkg::DEPTH_BITS-1:0]      rsp_free_pages
);

   localparam int PB = rpa_pkg::PAGE_BITS;
   localparam int CB = rpa_pkg::COUNT_BITS;
   localparam int DB = rpa_pkg::DEPTH_BITS;

   logic [CB-1:0] cnt_mem   [rpa_pkg::NUM_PAGES];
   logic [PB-1:0] stack_mem [rpa_pkg::NUM_PAGES];

   logic [PB-1:0] first_ff;
   logic [DB-1:0] depth_ff, depth_in;
   logic [PB-1:0] clr_ff;
   logic [1:0]    mode_ff;
   logic [PB-1:0] page_ff;
   logic [CB-1:0] cnt_rd_ff;
   logic [PB-1:0] stack_rd_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PB-1:0] rsp_page_ff;
   logic [2:0]    rsp_status_ff;
   logic [CB-1:0] rsp_count_ff;
   logic [DB-1:0] rsp_free_ff;

   logic [DB-1:0] top_idx;
   logic          pop_ok;
   logic          do_push, do_pop, do_wr, need_w2;
   logic [PB-1:0] wr_addr;
   logic [CB-1:0] wr_data;
   logic [PB-1:0] res_page;
   logic [2:0]    res_status;
   logic [CB-1:0] res_count;
   logic [CB-1:0] dec_cnt;
   logic          mem_we;
   logic [PB-1:0] mem_waddr;
   logic [CB-1:0] mem_wdata;

   assign top_idx = depth_ff - DB'(1);
   assign pop_ok  = depth_ff != '0;
   assign dec_cnt = (cnt_rd_ff != '0) ? cnt_rd_ff - CB'(1) : '0;

   // work out the whole operation from the registered reads
   always_comb begin
      do_push    = 1'b0;
      do_pop     = 1'b0;
      do_wr      = 1'b0;
      need_w2    = 1'b0;
      wr_addr    = page_ff;
      wr_data    = '0;
      res_page   = '0;
      res_status = rpa_pkg::ST_OK;
      res_count  = '0;
      case (mode_ff)
         rpa_pkg::MODE_ALLOC: begin
            if (!pop_ok) begin
               res_status = rpa_pkg::ST_OOM;
            end else begin
               do_pop    = 1'b1;
               do_wr     = 1'b1;
               wr_addr   = stack_rd_ff;
               wr_data   = CB'(1);
               res_page  = stack_rd_ff;
               res_count = CB'(1);
            end
         end
         rpa_pkg::MODE_FREE: begin
            if (page_ff < first_ff) begin
               res_status = rpa_pkg::ST_BAD;
            end else begin
               do_wr     = 1'b1;
               wr_data   = dec_cnt;
               res_count = dec_cnt;
               if (dec_cnt == '0) begin
                  if (depth_ff < DB'(rpa_pkg::NUM_PAGES)) begin
                     do_push = 1'b1;
                  end else begin
                     res_status = rpa_pkg::ST_FULL;
                  end
               end
            end
         end
         rpa_pkg::MODE_ADDREF: begin
            if (cnt_rd_ff == rpa_pkg::COUNT_MAX) begin
               res_status = rpa_pkg::ST_SAT;
               res_count  = cnt_rd_ff;
            end else begin
               do_wr     = 1'b1;
               wr_data   = cnt_rd_ff + CB'(1);
               res_count = cnt_rd_ff + CB'(1);
            end
         end
         rpa_pkg::MODE_COW: begin
            if (cnt_rd_ff <= CB'(1)) begin
               res_page   = page_ff;
               res_status = rpa_pkg::ST_KEPT;
               res_count  = cnt_rd_ff;
            end else if (!pop_ok) begin
               res_status = rpa_pkg::ST_OOM;
               res_count  = cnt_rd_ff;
            end else begin
               do_pop   = 1'b1;
               do_wr    = 1'b1;
               res_page = stack_rd_ff;
               if (stack_rd_ff == page_ff) begin
                  // popped the shared page itself: set to one, then dropped
                  wr_data   = '0;
                  res_count = '0;
               end else begin
                  wr_addr   = stack_rd_ff;
                  wr_data   = CB'(1);
                  need_w2   = 1'b1;
                  res_count = dec_cnt;
               end
            end
         end
         default: begin
            res_status = rpa_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      depth_in = depth_ff;
      if (cmd.exec && do_push) depth_in = depth_ff + DB'(1);
      if (cmd.exec && do_pop)  depth_in = top_idx;
   end

   // single write port on the count memory
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = page_ff;
      mem_wdata = '0;
      if (cmd.clear_en) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end else if (cmd.exec) begin
         mem_we    = do_wr;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end else if (cmd.write2) begin
         mem_we    = 1'b1;
         mem_wdata = dec_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) cnt_mem[mem_waddr] <= mem_wdata;
      if (cmd.accept) cnt_rd_ff <= cnt_mem[req_page_number];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && do_push) stack_mem[depth_ff[PB-1:0]] <= page_ff;
      if (cmd.accept) stack_rd_ff <= stack_mem[top_idx[PB-1:0]];
   end

   assign rsp_valid_in = cmd.exec | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         depth_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) first_ff <= csr_first_usable_page;
         depth_ff     <= depth_in;
         if (cmd.clear_en) clr_ff <= clr_ff + PB'(1);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         page_ff <= req_page_number;
      end
      if (cmd.exec) begin
         rsp_page_ff   <= res_page;
         rsp_status_ff <= res_status;
         rsp_count_ff  <= res_count;
         rsp_free_ff   <= depth_in;
      end
   end

   assign status.clear_last  = clr_ff == {PB{1'b1}};
   assign status.slot_free   = ~rsp_valid_ff | rsp_ready;
   assign status.need_write2 = need_w2;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_ref_count   = rsp_count_ff;
   assign rsp_free_pages  = rsp_free_ff;

endmodule

[rtl/core/refcounted_page_allocator_unit.sv]
// refcounted_page_allocator_unit: top level joining rpa_ctrl and rpa_dpath
// depends on rpa_pkg, rpa_ctrl, rpa_dpath
//
//  channel | ports                                             | direction
//  req     | req_valid/req_ready, req_mode, req_page_number    | in
//  rsp     | rsp_valid/rsp_ready, result_page, status, ref_count,
//          | free_pages                                        | out
//  csr     | csr_valid/csr_ready, csr_first_usable_page        | in
//
// one request at a time: each is accepted with a memory read, then executed
// with writes; a copy-on-write that allocates a distinct page needs a second
// count write, set by the single write port of the count memory
// after reset a clearing sweep zeroes all 32768 counts, one per cycle;
// req_ready stays low during the sweep, csr writes are taken throughout
// a stalled response holds the execute step; the next request is taken
// while the last result still waits in the response register
`timescale 1ns / 1ps

module refcounted_page_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic [rpa_pkg::PAGE_BITS-1:0]      req_page_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rpa_pkg::PAGE_BITS-1:0]      rsp_result_page,
   output logic [2:0]                         rsp_status,
   output logic [rpa_pkg::COUNT_BITS-1:0]     rsp_ref_count,
   output logic [rpa_pkg::DEPTH_BITS-1:0]     rsp_free_pages,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rpa_pkg::PAGE_BITS-1:0]      csr_first_usable_page
);

   rpa_pkg::ctrl_cmd_type  cmd;
   rpa_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpa_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_mode              (req_mode),
      .req_page_number       (req_page_number),
      .csr_valid             (csr_valid),
      .csr_first_usable_page (csr_first_usable_page),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_page       (rsp_result_page),
      .rsp_status            (rsp_status),
      .rsp_ref_count         (rsp_ref_count),
      .rsp_free_pages        (rsp_free_pages)
   );

endmodule

[rtl/core/rpa_checker.sv]
// rpa_checker: port-level assertions for refcounted_page_allocator_unit,
// bound to the top level; depends on rpa_pkg
`timescale 1ns / 1ps

module rpa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rpa_pkg::PAGE_BITS-1:0]      rsp_result_page,
   input logic [2:0]                         rsp_status,
   input logic [rpa_pkg::DEPTH_BITS-1:0]     rsp_free_pages
);

   // clear sweep follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another executes");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_page)
                                  && $stable(rsp_status))
      else $error("stalled response beat changed");

   a_oom_no_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rpa_pkg::ST_OOM || rsp_status == rpa_pkg::ST_BAD)
      |-> rsp_result_page == '0)
      else $error("failed request returned a page");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_pages <= rpa_pkg::DEPTH_BITS'(rpa_pkg::NUM_PAGES)
                    && rsp_status <= rpa_pkg::ST_FULL)
      else $error("response out of range");

endmodule

bind refcounted_page_allocator_unit rpa_checker u_rpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_page (rsp_result_page),
   .rsp_status      (rsp_status),
   .rsp_free_pages  (rsp_free_pages)
);
